/* src/sasmd_pkg.sv */
// Shared types and constants for the subarray sum multiple detector.
`default_nettype none
package sasmd_pkg;

  localparam int unsigned VALUE_W   = 31;
  localparam int unsigned MODULUS_W = 11;
  localparam int unsigned DIVIDEND_W = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIVIDEND_W);
  localparam int unsigned EPOCH_W   = 8;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } sasmd_in_t;

  typedef struct packed {
    logic found;
    logic last_out;
  } sasmd_out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_EVAL
  } sasmd_state_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic rd_en;
    logic eval;
    logic clear_step;
  } sasmd_cmd_t;

  typedef struct packed {
    logic mode_zero;
    logic div_done;
    logic out_full;
    logic clear_done;
    logic epoch_wrap;
  } sasmd_status_t;

endpackage
`default_nettype wire

/* src/subarray_sum_multiple_detector.sv */
// Top level of the subarray sum multiple detector: controller plus datapath.
// With a nonzero modulus an accepted beat takes 32 bit-serial remainder steps on the 32-bit
// prefix sum, one table read and one evaluation, which registers the result beat; with modulus
// zero it goes straight to evaluation. A new beat is accepted only once the last one is evaluated,
// and evaluation waits while the output holds a result under out_stall. Reset: synchronous
// active-low rst_n restores modulus 1, clears the array state, then sweeps the table (in_stall
// high); the sweep also follows every 255th array as the table epoch tag wraps.
`default_nettype none
module subarray_sum_multiple_detector
  import sasmd_pkg::*;
#(
  parameter int unsigned     MAX_MODULUS = 1024,
  parameter longint unsigned MAX_LENGTH  = 65535
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire sasmd_in_t            in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output sasmd_out_t                out_data,
  input  wire logic                 cfg_wr_en,
  input  wire logic [MODULUS_W-1:0] cfg_wr_data
);

  // The controller owns sequencing and the input handshake; the datapath owns every
  // register that carries array state, the remainder unit, the table memory and the
  // output register, which lets a finished beat wait while the next one is taken.
  sasmd_cmd_t    cmd;
  sasmd_status_t status;

  sasmd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Table entries are tagged with an array epoch, so the per-array clearing of the valid
  // marks costs nothing except the occasional sweep when the tag wraps. The sweep clears all
  // 2**clog2(min(MAX_MODULUS,2048)) table entries.
  sasmd_dpath #(
    .MAX_MODULUS (MAX_MODULUS),
    .MAX_LENGTH  (MAX_LENGTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .out_data    (out_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status)
  );

endmodule
`default_nettype wire

/* src/sasmd_ctrl.sv */
// Controller state machine that sequences one beat through the datapath.
`default_nettype none
module sasmd_ctrl
  import sasmd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire sasmd_status_t status,
  output sasmd_cmd_t         cmd
);

  sasmd_state_t state_r;
  sasmd_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (status.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = status.mode_zero ? S_EVAL : S_DIV;
      end
      S_DIV: begin
        if (status.div_done) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!status.out_full) state_nxt = status.epoch_wrap ? S_CLEAR : S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
      end
      S_EVAL: begin
        cmd.eval = !status.out_full;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/sasmd_dpath.sv */
// Datapath: bit-serial remainder unit, first-position table, array state and result register.
`default_nettype none
module sasmd_dpath
  import sasmd_pkg::*;
#(
  parameter int unsigned     MAX_MODULUS = 1024,
  parameter longint unsigned MAX_LENGTH  = 65535
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sasmd_in_t            in_data,
  output sasmd_out_t                out_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire logic                 cfg_wr_en,
  input  wire logic [MODULUS_W-1:0] cfg_wr_data,
  input  wire sasmd_cmd_t           cmd,
  output sasmd_status_t             status
);

  localparam int unsigned RW    = $clog2((MAX_MODULUS < 2048) ? MAX_MODULUS : 2048);
  localparam int unsigned DEPTH = 2 ** RW;
  localparam int unsigned CW    = $clog2(MAX_LENGTH + 1);
  localparam int unsigned ENT_W = EPOCH_W + CW;

  logic [MODULUS_W-1:0]  modulus_r;
  logic [MODULUS_W-1:0]  m_eff;

  logic [VALUE_W-1:0]    value_r;
  logic                  last_r;
  logic [DIVIDEND_W-1:0] dividend_r;
  logic [MODULUS_W-1:0]  rem_r;
  logic [DIV_CNT_W-1:0]  div_cnt_r;

  logic [RW-1:0]         prefix_r;
  logic [CW-1:0]         count_r;
  logic                  prev_zero_r;
  logic                  found_r;
  logic [EPOCH_W-1:0]    epoch_r;
  logic [RW-1:0]         clr_cnt_r;

  logic [ENT_W-1:0]      mem [DEPTH];
  logic [ENT_W-1:0]      rd_data_r;

  sasmd_out_t            out_r;
  logic                  out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_W'(1);
    end else if (cfg_wr_en) begin
      modulus_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (32'(modulus_r) > 32'(MAX_MODULUS)) m_eff = MODULUS_W'(MAX_MODULUS);
    else m_eff = modulus_r;
  end

  // Restoring remainder, one dividend bit per step.
  logic [MODULUS_W:0] trial;
  always_comb begin
    trial = {rem_r, dividend_r[DIVIDEND_W-1]};
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      value_r    <= in_data.value;
      last_r     <= in_data.last;
      dividend_r <= DIVIDEND_W'(in_data.value) + DIVIDEND_W'(prefix_r);
      rem_r      <= '0;
    end else if (cmd.div_step) begin
      dividend_r <= {dividend_r[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, m_eff}) rem_r <= MODULUS_W'(trial - {1'b0, m_eff});
      else rem_r <= trial[MODULUS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.accept) begin
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  // Evaluation of one beat.
  logic [RW-1:0]      r_new;
  logic [CW-1:0]      ent_pos;
  logic [EPOCH_W-1:0] ent_epoch;
  logic               ent_valid;
  logic               hit;
  logic               do_write;
  logic               found_nxt;

  always_comb begin
    r_new     = rem_r[RW-1:0];
    ent_pos   = rd_data_r[CW-1:0];
    ent_epoch = rd_data_r[ENT_W-1:CW];
    ent_valid = (ent_epoch == epoch_r);
    hit       = 1'b0;
    do_write  = 1'b0;
    if (status.mode_zero) begin
      hit = (count_r != '0) && prev_zero_r && (value_r == '0);
    end else if (r_new == '0) begin
      hit = (count_r != '0);
    end else if (ent_valid) begin
      hit = (count_r >= ent_pos) && ((count_r - ent_pos) >= CW'(2));
    end else if (count_r < CW'(MAX_LENGTH)) begin
      do_write = 1'b1;
    end
    found_nxt = found_r | hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r    <= '0;
      count_r     <= '0;
      prev_zero_r <= 1'b0;
      found_r     <= 1'b0;
      epoch_r     <= EPOCH_W'(1);
      clr_cnt_r   <= '0;
    end else if (cmd.clear_step) begin
      epoch_r   <= EPOCH_W'(1);
      clr_cnt_r <= clr_cnt_r + RW'(1);
    end else if (cmd.eval) begin
      if (last_r) begin
        prefix_r    <= '0;
        count_r     <= '0;
        prev_zero_r <= 1'b0;
        found_r     <= 1'b0;
        epoch_r     <= epoch_r + EPOCH_W'(1);
      end else begin
        if (!status.mode_zero) prefix_r <= r_new;
        if (count_r < CW'(MAX_LENGTH)) count_r <= count_r + CW'(1);
        prev_zero_r <= (value_r == '0);
        found_r     <= found_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.eval && do_write) begin
      mem[r_new] <= {epoch_r, count_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[r_new];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.eval) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      out_r.found    <= found_nxt;
      out_r.last_out <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    status.mode_zero  = (m_eff == '0);
    status.div_done   = (div_cnt_r == '1);
    status.out_full   = out_valid_r && out_stall;
    status.clear_done = (clr_cnt_r == '1);
    status.epoch_wrap = last_r && (epoch_r == '1);
  end

endmodule
`default_nettype wire
